[rtl/hbr_pkg.sv]
package hbr_pkg;

    localparam int STATUS_W = 3;
    localparam int OUT_SLOT_W = 10;
    localparam int NUM_W = 32;
    localparam int WORD_W = 64;
    localparam int FILL_W = 12;
    localparam int SIZE_W = 11;

    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OPEN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [NUM_W-1:0] NUM_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                do_write;
        logic                do_read;
    } ctl_t;

endpackage

[rtl/hbr_req_if.sv]
interface hbr_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [hbr_pkg::NUM_W-1:0]   block_number;
    logic [hbr_pkg::WORD_W-1:0]  payload_word;
    logic [hbr_pkg::FILL_W-1:0]  payload_fill;

    modport source (output valid, opcode, block_number, payload_word, payload_fill,
                    input ready);
    modport sink (input valid, opcode, block_number, payload_word, payload_fill,
                  output ready);
endinterface

[rtl/hbr_rsp_if.sv]
interface hbr_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [hbr_pkg::STATUS_W-1:0]    status;
    logic [hbr_pkg::OUT_SLOT_W-1:0]  slot;
    logic [hbr_pkg::WORD_W-1:0]      read_payload;
    logic [hbr_pkg::FILL_W-1:0]      read_fill;
    logic [hbr_pkg::NUM_W-1:0]       newest_number;

    modport source (output valid, status, slot, read_payload, read_fill, newest_number,
                    input ready);
    modport sink (input valid, status, slot, read_payload, read_fill, newest_number,
                  output ready);
endinterface

[rtl/hbr_cfg_if.sv]
interface hbr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [hbr_pkg::SIZE_W-1:0]  ring_size;

    modport source (output valid, ring_size, input ready);
    modport sink (input valid, ring_size, output ready);
endinterface

[rtl/hbr_front.sv]
module hbr_front #(
    parameter int DEPTH = 1024,
    parameter int PAYLOAD_BITS = 64,
    parameter int SLOT_W = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    hbr_req_if.sink                     req,
    hbr_cfg_if.sink                     cfg,
    output logic                        push_valid,
    input  logic                        push_ready,
    output hbr_pkg::ctl_t               push_ctl,
    output logic [SLOT_W-1:0]           push_slot,
    output logic [PAYLOAD_BITS-1:0]     push_word,
    output logic [hbr_pkg::FILL_W-1:0]  push_fill,
    output logic [hbr_pkg::NUM_W-1:0]   push_newest
);

    localparam int AW = ((SLOT_W > hbr_pkg::SIZE_W) ? SLOT_W : hbr_pkg::SIZE_W) + 1;

    logic [hbr_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [hbr_pkg::SIZE_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0]          nslot_reg, nslot_next;
    logic [hbr_pkg::NUM_W-1:0]  nabs_reg, nabs_next;
    logic                       any_reg, any_next;

    logic                       fire;
    logic                       cfg_fire;
    logic [hbr_pkg::SIZE_W-1:0] cfg_sat;
    logic [hbr_pkg::NUM_W:0]    open_num;
    logic [hbr_pkg::NUM_W-1:0]  delta;
    logic [AW-1:0]              delta_n;
    logic [AW-1:0]              nslot_w;
    logic [AW-1:0]              size_w;
    logic [AW-1:0]              inc_slot;
    logic [AW-1:0]              rd_slot;

    // a ring size write holds off the request for that cycle
    assign fire = req.valid && req.ready;
    assign req.ready = push_ready && !cfg.valid;
    assign push_valid = req.valid && !cfg.valid;
    assign push_word = req.payload_word[PAYLOAD_BITS-1:0];
    assign push_fill = req.payload_fill;

    assign cfg.ready = 1'b1;
    assign cfg_fire = cfg.valid;
    assign cfg_sat = (32'(cfg.ring_size) > 32'(DEPTH)) ? hbr_pkg::SIZE_W'(DEPTH)
                                                       : cfg.ring_size;

    assign nslot_w = AW'(nslot_reg);
    assign size_w = AW'(size_reg);
    assign inc_slot = nslot_w + AW'(1);
    assign open_num = any_reg ? ({1'b0, nabs_reg} + 33'd1) : '0;
    assign delta = nabs_reg - req.block_number;
    assign delta_n = AW'(delta);
    assign rd_slot = (nslot_w >= delta_n) ? (nslot_w - delta_n)
                                          : (nslot_w + size_w - delta_n);

    always_comb
    begin
        push_ctl.status = hbr_pkg::ST_OK;
        push_ctl.do_write = 1'b0;
        push_ctl.do_read = 1'b0;
        push_slot = '0;
        count_next = count_reg;
        nslot_next = nslot_reg;
        nabs_next = nabs_reg;
        any_next = any_reg;
        if (size_reg == '0)
        begin
            push_ctl.status = hbr_pkg::ST_DISABLED;
        end
        else if (req.opcode == hbr_pkg::OP_APPEND)
        begin
            if (any_reg && nabs_reg == hbr_pkg::NUM_MAX)
            begin
                push_ctl.status = hbr_pkg::ST_EXHAUSTED;
            end
            else
            begin
                push_ctl.do_write = 1'b1;
                if (any_reg)
                begin
                    push_slot = (inc_slot >= size_w) ? '0 : SLOT_W'(inc_slot);
                    nabs_next = nabs_reg + 32'd1;
                end
                else
                begin
                    push_slot = '0;
                    nabs_next = '0;
                end
                nslot_next = push_slot;
                any_next = 1'b1;
                if (count_reg < size_reg)
                begin
                    count_next = count_reg + 11'd1;
                end
            end
        end
        else
        begin
            if ({1'b0, req.block_number} == open_num)
            begin
                push_ctl.status = hbr_pkg::ST_OPEN;
            end
            else if (!any_reg || req.block_number > nabs_reg ||
                     delta >= 32'(count_reg))
            begin
                push_ctl.status = hbr_pkg::ST_ABSENT;
            end
            else
            begin
                push_ctl.do_read = 1'b1;
                push_slot = SLOT_W'(rd_slot);
            end
        end
        push_newest = any_next ? nabs_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
            count_reg <= '0;
            nslot_reg <= '0;
            nabs_reg <= '0;
            any_reg <= 1'b0;
        end
        else if (cfg_fire)
        begin
            if (cfg_sat != size_reg)
            begin
                size_reg <= cfg_sat;
                count_reg <= '0;
                nslot_reg <= '0;
                nabs_reg <= '0;
                any_reg <= 1'b0;
            end
        end
        else if (fire)
        begin
            count_reg <= count_next;
            nslot_reg <= nslot_next;
            nabs_reg <= nabs_next;
            any_reg <= any_next;
        end
    end

endmodule

[rtl/hbr_queue.sv]
module hbr_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    localparam int ENTRIES = 2;

    logic [W-1:0] data_reg [ENTRIES];
    logic         wptr_reg, wptr_next;
    logic         rptr_reg, rptr_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         push;
    logic         pop;

    assign push_ready = (cnt_reg != 2'(ENTRIES));
    assign pop_valid = (cnt_reg != 2'd0);
    assign pop_data = data_reg[rptr_reg];
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wptr_reg] <= push_data;
        end
    end

endmodule

[rtl/hbr_back.sv]
module hbr_back #(
    parameter int DEPTH = 1024,
    parameter int PAYLOAD_BITS = 64,
    parameter int SLOT_W = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  hbr_pkg::ctl_t               pop_ctl,
    input  logic [SLOT_W-1:0]           pop_slot,
    input  logic [PAYLOAD_BITS-1:0]     pop_word,
    input  logic [hbr_pkg::FILL_W-1:0]  pop_fill,
    input  logic [hbr_pkg::NUM_W-1:0]   pop_newest,
    hbr_rsp_if.source                   rsp
);

    localparam int MW = PAYLOAD_BITS + hbr_pkg::FILL_W;

    logic [MW-1:0]                  mem [DEPTH];
    logic [MW-1:0]                  rd_reg;
    logic                           valid_reg;
    logic                           hit_reg;
    logic [hbr_pkg::STATUS_W-1:0]   status_reg;
    logic [SLOT_W-1:0]              slot_reg;
    logic [hbr_pkg::NUM_W-1:0]      newest_reg;
    logic                           pop;

    assign pop_ready = !valid_reg || rsp.ready;
    assign pop = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= pop_ctl.status;
            slot_reg <= pop_slot;
            newest_reg <= pop_newest;
            hit_reg <= pop_ctl.do_read;
            if (pop_ctl.do_write)
            begin
                mem[pop_slot] <= {pop_word, pop_fill};
            end
            if (pop_ctl.do_read)
            begin
                rd_reg <= mem[pop_slot];
            end
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.status = status_reg;
    assign rsp.slot = hbr_pkg::OUT_SLOT_W'(slot_reg);
    assign rsp.newest_number = newest_reg;
    assign rsp.read_payload = hit_reg ? hbr_pkg::WORD_W'(rd_reg[MW-1:hbr_pkg::FILL_W]) : '0;
    assign rsp.read_fill = hit_reg ? rd_reg[hbr_pkg::FILL_W-1:0] : '0;

endmodule

[rtl/history_block_ring_unit.sv]
// An accepted request is registered in a queue entry, then its memory access is
// registered in the output register. Throughput: one request per cycle sustained
// while rsp.ready is high; the single-port ring memory takes one access per
// cycle. A ring size write holds off requests for its cycle.
// Reset: rst_n async low clears ring size (block disabled), counts and queue.
module history_block_ring_unit #(
    parameter int DEPTH = 1024,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    hbr_req_if.sink   req,
    hbr_cfg_if.sink   cfg,
    hbr_rsp_if.source rsp
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int QW = $bits(hbr_pkg::ctl_t) + SLOT_W + PAYLOAD_BITS
                        + hbr_pkg::FILL_W + hbr_pkg::NUM_W;

    logic                        push_valid;
    logic                        push_ready;
    hbr_pkg::ctl_t               push_ctl;
    logic [SLOT_W-1:0]           push_slot;
    logic [PAYLOAD_BITS-1:0]     push_word;
    logic [hbr_pkg::FILL_W-1:0]  push_fill;
    logic [hbr_pkg::NUM_W-1:0]   push_newest;

    logic                        pop_valid;
    logic                        pop_ready;
    hbr_pkg::ctl_t               pop_ctl;
    logic [SLOT_W-1:0]           pop_slot;
    logic [PAYLOAD_BITS-1:0]     pop_word;
    logic [hbr_pkg::FILL_W-1:0]  pop_fill;
    logic [hbr_pkg::NUM_W-1:0]   pop_newest;

    logic [QW-1:0]               q_in;
    logic [QW-1:0]               q_out;

    hbr_front #(
        .DEPTH(DEPTH),
        .PAYLOAD_BITS(PAYLOAD_BITS),
        .SLOT_W(SLOT_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .cfg(cfg),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_ctl(push_ctl),
        .push_slot(push_slot),
        .push_word(push_word),
        .push_fill(push_fill),
        .push_newest(push_newest)
    );

    assign q_in = {push_ctl, push_slot, push_word, push_fill, push_newest};
    assign {pop_ctl, pop_slot, pop_word, pop_fill, pop_newest} = q_out;

    hbr_queue #(
        .W(QW)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data(q_in),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_data(q_out)
    );

    hbr_back #(
        .DEPTH(DEPTH),
        .PAYLOAD_BITS(PAYLOAD_BITS),
        .SLOT_W(SLOT_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_ctl(pop_ctl),
        .pop_slot(pop_slot),
        .pop_word(pop_word),
        .pop_fill(pop_fill),
        .pop_newest(pop_newest),
        .rsp(rsp)
    );

endmodule
